[rtl/ac_pkg.sv]
// Shared types and constants for the Aho-Corasick matcher.
package ac_pkg;

    localparam int NUM_NODES = 256;
    localparam int ALPHABET  = 256;
    localparam int NODE_W    = $clog2(NUM_NODES);
    localparam int SYM_W     = $clog2(ALPHABET);
    localparam int CNT_W     = NODE_W + 1;
    localparam int EDGE_AW   = NODE_W + SYM_W;

    typedef enum logic [1:0] {
        MODE_CLEAR = 2'd0,
        MODE_ADD   = 2'd1,
        MODE_BUILD = 2'd2,
        MODE_SCAN  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_BUILT = 2'd2
    } t_status;

    typedef struct packed {
        t_mode             mode;
        logic [SYM_W-1:0]  data_byte;
        logic              last_byte;
        logic              start_of_text;
    } t_req;

    typedef struct packed {
        t_status           status;
        logic [NODE_W-1:0] node;
        logic              match;
    } t_rsp;

endpackage

[rtl/ac_if.sv]
// Valid/ready channel interfaces for requests and results.
interface ac_req_if import ac_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ac_rsp_if import ac_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/ac_ram.sv]
// Generic simple dual-port RAM, one write port, one registered read port.
module ac_ram #(
    parameter int W = 8,
    parameter int D = 256
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/aho_corasick_matcher.sv]
// Top level of the Aho-Corasick multi-pattern byte matcher.
//
// Channels: i_req carries one request {mode, data_byte, last_byte,
// start_of_text}; o_rsp returns exactly one result {status, node, match} per
// request. Both are valid/ready; a request moves when valid and ready are high.
// The engine works on one request at a time: i_req.ready is high only while
// the sequencer is idle. All tables live in RAMs with a registered read, and
// one read of the edge table per step paces everything.
//   clear:         root row wiped, then the result goes to the output register
//   add, old edge: edge and mark read;  add, new node: new row wiped
//   scan:          edge read, then failure-link hops until an edge or the root
//   build:         root row swept, then per queued node its row swept,
//                  and for each child found its failure chain walked
// Reset (synchronous, active low) starts the same root-row wipe;
// no request is taken until it ends and no result is produced for it.
// A finished result sits in the output register; if the receiver stalls the
// engine still takes the next request, and only waits at the point where a
// second result would have to overwrite the one not yet taken.
// Rows of the edge table are wiped when a node is created, so stale edges
// from before a clear are never seen.
module aho_corasick_matcher import ac_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ac_req_if.sink    i_req,
    ac_rsp_if.source  o_rsp
);

    typedef enum logic [18:0] {
        S_IDLE  = 19'd1,
        S_CLR   = 19'd2,
        S_OUT   = 19'd4,
        S_ADD_W = 19'd8,
        S_ADD_M = 19'd16,
        S_ROW   = 19'd32,
        S_SC_W  = 19'd64,
        S_SC_FL = 19'd128,
        S_SC_EM = 19'd256,
        S_B1    = 19'd512,
        S_B1_W  = 19'd1024,
        S_B_HD  = 19'd2048,
        S_B_HW  = 19'd4096,
        S_B_FW  = 19'd8192,
        S_B_CH  = 19'd16384,
        S_B_CW  = 19'd32768,
        S_B_FC  = 19'd65536,
        S_B_FCW = 19'd131072,
        S_B_EW  = 19'd262144
    } t_state;

    localparam logic [SYM_W-1:0]  SYM_LAST = {SYM_W{1'b1}};
    localparam logic [NODE_W-1:0] ROOT     = '0;

    t_state             r_state, n_state;
    logic [SYM_W-1:0]   r_k, n_k;          // symbol / sweep counter
    logic [NODE_W-1:0]  r_cur, n_cur;      // pattern cursor
    logic [NODE_W-1:0]  r_scan, n_scan;    // scan position
    logic               r_built, n_built;
    logic [CNT_W-1:0]   r_cnt, n_cnt;      // nodes in use
    logic               r_clr_res, n_clr_res;
    logic [SYM_W-1:0]   r_sym, n_sym;
    logic               r_last, n_last;
    logic [NODE_W-1:0]  r_s, n_s;          // scan walk node
    logic [NODE_W-1:0]  r_nx, n_nx;
    logic [NODE_W-1:0]  r_head, n_head;
    logic [NODE_W-1:0]  r_tail, n_tail;
    logic [NODE_W-1:0]  r_st, n_st;
    logic [NODE_W-1:0]  r_fst, n_fst;
    logic [NODE_W-1:0]  r_fs, n_fs;
    t_rsp               r_res, n_res;      // result being formed
    logic               r_ov, n_ov;
    t_rsp               r_od, n_od;

    // RAM ports
    logic               c_we;
    logic [EDGE_AW-1:0] c_waddr, c_raddr;
    logic [NODE_W-1:0]  c_wdata, c_rdata;
    logic               f_we;
    logic [NODE_W-1:0]  f_waddr, f_raddr, f_wdata, f_rdata;
    logic               e_we;
    logic [NODE_W-1:0]  e_waddr, e_raddr;
    logic               e_wdata, e_rdata;
    logic               q_we;
    logic [NODE_W-1:0]  q_waddr, q_raddr, q_wdata, q_rdata;

    ac_ram #(.W(NODE_W), .D(NUM_NODES * ALPHABET)) u_child (
        .i_clk(i_clk), .i_we(c_we), .i_waddr(c_waddr), .i_wdata(c_wdata),
        .i_raddr(c_raddr), .o_rdata(c_rdata)
    );
    ac_ram #(.W(NODE_W), .D(NUM_NODES)) u_fail (
        .i_clk(i_clk), .i_we(f_we), .i_waddr(f_waddr), .i_wdata(f_wdata),
        .i_raddr(f_raddr), .o_rdata(f_rdata)
    );
    ac_ram #(.W(1), .D(NUM_NODES)) u_mark (
        .i_clk(i_clk), .i_we(e_we), .i_waddr(e_waddr), .i_wdata(e_wdata),
        .i_raddr(e_raddr), .o_rdata(e_rdata)
    );
    ac_ram #(.W(NODE_W), .D(NUM_NODES)) u_queue (
        .i_clk(i_clk), .i_we(q_we), .i_waddr(q_waddr), .i_wdata(q_wdata),
        .i_raddr(q_raddr), .o_rdata(q_rdata)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_ov;
    assign o_rsp.data  = r_od;

    always_comb begin
        n_state   = r_state;
        n_k       = r_k;
        n_cur     = r_cur;
        n_scan    = r_scan;
        n_built   = r_built;
        n_cnt     = r_cnt;
        n_clr_res = r_clr_res;
        n_sym     = r_sym;
        n_last    = r_last;
        n_s       = r_s;
        n_nx      = r_nx;
        n_head    = r_head;
        n_tail    = r_tail;
        n_st      = r_st;
        n_fst     = r_fst;
        n_fs      = r_fs;
        n_res     = r_res;
        n_ov      = r_ov;
        n_od      = r_od;

        c_we = 1'b0; c_waddr = '0; c_wdata = '0; c_raddr = '0;
        f_we = 1'b0; f_waddr = '0; f_wdata = '0; f_raddr = '0;
        e_we = 1'b0; e_waddr = '0; e_wdata = 1'b0; e_raddr = '0;
        q_we = 1'b0; q_waddr = '0; q_wdata = '0; q_raddr = '0;

        if (r_ov && o_rsp.ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_sym  = i_req.data.data_byte;
                    n_last = i_req.data.last_byte;
                    n_res  = '{status: ST_OK, node: ROOT, match: 1'b0};
                    unique case (i_req.data.mode)
                        MODE_CLEAR: begin
                            n_k       = '0;
                            n_clr_res = 1'b1;
                            n_state   = S_CLR;
                        end
                        MODE_ADD: begin
                            n_built = 1'b0;
                            c_raddr = {r_cur, i_req.data.data_byte};
                            e_raddr = r_cur;
                            n_state = S_ADD_W;
                        end
                        MODE_BUILD: begin
                            n_k     = '0;
                            n_head  = '0;
                            n_tail  = '0;
                            n_state = S_B1;
                        end
                        MODE_SCAN: begin
                            if (!r_built) begin
                                n_res.status = ST_NOT_BUILT;
                                n_state      = S_OUT;
                            end else begin
                                n_s     = i_req.data.start_of_text ? ROOT : r_scan;
                                c_raddr = {(i_req.data.start_of_text ? ROOT : r_scan),
                                           i_req.data.data_byte};
                                n_state = S_SC_W;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_CLR: begin
                c_we    = 1'b1;
                c_waddr = {ROOT, r_k};
                e_we    = 1'b1;
                e_waddr = ROOT;
                n_k     = r_k + 1'b1;
                if (r_k == SYM_LAST) begin
                    n_cnt   = CNT_W'(1);
                    n_cur   = ROOT;
                    n_scan  = ROOT;
                    n_built = 1'b0;
                    n_res   = '{status: ST_OK, node: ROOT, match: 1'b0};
                    n_state = r_clr_res ? S_OUT : S_IDLE;
                end
            end
            S_ADD_W: begin
                if (c_rdata == ROOT && r_cnt >= CNT_W'(NUM_NODES)) begin
                    n_res = '{status: ST_FULL, node: r_cur, match: e_rdata};
                    if (r_last) begin
                        n_cur = ROOT;
                    end
                    n_state = S_OUT;
                end else if (c_rdata == ROOT) begin
                    c_we    = 1'b1;
                    c_waddr = {r_cur, r_sym};
                    c_wdata = r_cnt[NODE_W-1:0];
                    e_we    = 1'b1;
                    e_waddr = r_cnt[NODE_W-1:0];
                    e_wdata = r_last;
                    n_nx    = r_cnt[NODE_W-1:0];
                    n_cnt   = r_cnt + 1'b1;
                    n_cur   = r_last ? ROOT : r_cnt[NODE_W-1:0];
                    n_res   = '{status: ST_OK, node: r_cnt[NODE_W-1:0], match: r_last};
                    n_k     = '0;
                    n_state = S_ROW;
                end else begin
                    n_nx  = c_rdata;
                    n_cur = r_last ? ROOT : c_rdata;
                    if (r_last) begin
                        e_we    = 1'b1;
                        e_waddr = c_rdata;
                        e_wdata = 1'b1;
                        n_res   = '{status: ST_OK, node: c_rdata, match: 1'b1};
                        n_state = S_OUT;
                    end else begin
                        e_raddr = c_rdata;
                        n_state = S_ADD_M;
                    end
                end
            end
            S_ADD_M: begin
                n_res   = '{status: ST_OK, node: r_nx, match: e_rdata};
                n_state = S_OUT;
            end
            S_ROW: begin
                // wipe the fresh node's edge row
                c_we    = 1'b1;
                c_waddr = {r_nx, r_k};
                n_k     = r_k + 1'b1;
                if (r_k == SYM_LAST) begin
                    n_state = S_OUT;
                end
            end
            S_SC_W: begin
                if (c_rdata != ROOT || r_s == ROOT) begin
                    n_scan  = c_rdata;
                    e_raddr = c_rdata;
                    n_state = S_SC_EM;
                end else begin
                    f_raddr = r_s;
                    n_state = S_SC_FL;
                end
            end
            S_SC_FL: begin
                n_s     = f_rdata;
                c_raddr = {f_rdata, r_sym};
                n_state = S_SC_W;
            end
            S_SC_EM: begin
                n_res   = '{status: ST_OK, node: r_scan, match: e_rdata};
                n_state = S_OUT;
            end
            S_B1: begin
                c_raddr = {ROOT, r_k};
                n_state = S_B1_W;
            end
            S_B1_W: begin
                if (c_rdata != ROOT) begin
                    f_we    = 1'b1;
                    f_waddr = c_rdata;
                    f_wdata = ROOT;
                    q_we    = 1'b1;
                    q_waddr = r_tail;
                    q_wdata = c_rdata;
                    n_tail  = r_tail + 1'b1;
                end
                n_k     = r_k + 1'b1;
                n_state = (r_k == SYM_LAST) ? S_B_HD : S_B1;
            end
            S_B_HD: begin
                if (r_head == r_tail) begin
                    n_built = 1'b1;
                    n_scan  = ROOT;
                    n_res   = '{status: ST_OK, node: ROOT, match: 1'b0};
                    n_state = S_OUT;
                end else begin
                    q_raddr = r_head;
                    n_head  = r_head + 1'b1;
                    n_state = S_B_HW;
                end
            end
            S_B_HW: begin
                n_st    = q_rdata;
                f_raddr = q_rdata;
                n_k     = '0;
                n_state = S_B_FW;
            end
            S_B_FW: begin
                n_fst   = f_rdata;
                n_state = S_B_CH;
            end
            S_B_CH: begin
                c_raddr = {r_st, r_k};
                n_state = S_B_CW;
            end
            S_B_CW: begin
                if (c_rdata == ROOT) begin
                    n_k     = r_k + 1'b1;
                    n_state = (r_k == SYM_LAST) ? S_B_HD : S_B_CH;
                end else begin
                    n_nx    = c_rdata;
                    q_we    = 1'b1;
                    q_waddr = r_tail;
                    q_wdata = c_rdata;
                    n_tail  = r_tail + 1'b1;
                    n_fs    = r_fst;
                    c_raddr = {r_fst, r_k};
                    n_state = S_B_FC;
                end
            end
            S_B_FC: begin
                if (c_rdata == ROOT && r_fs != ROOT) begin
                    f_raddr = r_fs;
                    n_state = S_B_FCW;
                end else begin
                    // edge found, or the chain is at the root: the edge read is the target
                    f_we    = 1'b1;
                    f_waddr = r_nx;
                    f_wdata = c_rdata;
                    e_raddr = c_rdata;
                    n_state = S_B_EW;
                end
            end
            S_B_FCW: begin
                n_fs    = f_rdata;
                c_raddr = {f_rdata, r_k};
                n_state = S_B_FC;
            end
            S_B_EW: begin
                if (e_rdata) begin
                    e_we    = 1'b1;
                    e_waddr = r_nx;
                    e_wdata = 1'b1;
                end
                n_k     = r_k + 1'b1;
                n_state = (r_k == SYM_LAST) ? S_B_HD : S_B_CH;
            end
            S_OUT: begin
                if (!r_ov || o_rsp.ready) begin
                    n_ov    = 1'b1;
                    n_od    = r_res;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_k       <= '0;
            r_cur     <= ROOT;
            r_scan    <= ROOT;
            r_built   <= 1'b0;
            r_cnt     <= CNT_W'(1);
            r_clr_res <= 1'b0;
            r_head    <= '0;
            r_tail    <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_k       <= n_k;
            r_cur     <= n_cur;
            r_scan    <= n_scan;
            r_built   <= n_built;
            r_cnt     <= n_cnt;
            r_clr_res <= n_clr_res;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_ov      <= n_ov;
        end
        r_sym  <= n_sym;
        r_last <= n_last;
        r_s    <= n_s;
        r_nx   <= n_nx;
        r_st   <= n_st;
        r_fst  <= n_fst;
        r_fs   <= n_fs;
        r_res  <= n_res;
        r_od   <= n_od;
    end

    // node count stays within the table
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt >= CNT_W'(1) && r_cnt <= CNT_W'(NUM_NODES))
        else $error("node count out of range");

    // pattern cursor always names a live node
    a_cur_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CNT_W'(r_cur) < r_cnt)
        else $error("pattern cursor beyond live nodes");

    // scan position always names a live node
    a_scan_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CNT_W'(r_scan) < r_cnt)
        else $error("scan node beyond live nodes");

    // BFS head never passes the tail
    a_queue_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= r_tail)
        else $error("queue head passed tail");

    // a result is loaded only when the output register is free or draining
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_ov && !o_rsp.ready) |=> r_state == S_OUT)
        else $error("result overwrote a pending one");

endmodule

[dv/ac_trie_checker.sv]
`timescale 1ns / 1ps
// Channel monitor, trie predictor and result comparison for the matcher.
module ac_trie_checker import ac_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    ac_req_if    req,
    ac_rsp_if    rsp,
    output int   o_errors,
    output int   o_pending
);

    bit [7:0] goto_edge[int];   // key node*256 + symbol, value child node
    bit [7:0] fail_to[NUM_NODES];
    bit       word_end[NUM_NODES];
    int       nodes_used;
    bit [7:0] add_cursor;
    bit [7:0] scan_at;
    bit       links_ready;
    t_rsp     expected_results[$];

    function automatic int child_of(int n, int sym);
        if (goto_edge.exists(n * ALPHABET + sym)) return goto_edge[n * ALPHABET + sym];
        return 0;
    endfunction

    function automatic void wipe_trie();
        goto_edge.delete();
        foreach (fail_to[i]) begin
            fail_to[i]  = 0;
            word_end[i] = 0;
        end
        nodes_used  = 1;
        add_cursor  = 0;
        scan_at     = 0;
        links_ready = 0;
    endfunction

    // Breadth-first failure links; marks flow in from each failure target.
    function automatic void link_trie();
        int order[$];
        int head, st, nx, fs, hops, tgt;
        head = 0;
        for (int s = 0; s < ALPHABET; s++) begin
            nx = child_of(0, s);
            if (nx != 0) begin
                fail_to[nx] = 0;
                order.push_back(nx);
            end
        end
        while (head < order.size()) begin
            st = order[head];
            head++;
            for (int s = 0; s < ALPHABET; s++) begin
                nx = child_of(st, s);
                if (nx == 0) continue;
                if (order.size() < NUM_NODES) order.push_back(nx);
                fs   = fail_to[st];
                hops = 0;
                while (child_of(fs, s) == 0 && fs != 0 && hops < NUM_NODES) begin
                    fs = fail_to[fs];
                    hops++;
                end
                tgt = child_of(fs, s);
                fail_to[nx]  = 8'(tgt);
                word_end[nx] = word_end[nx] | word_end[tgt];
            end
        end
        fail_to[0] = 0;
    endfunction

    function automatic int walk_text(int s, int sym);
        int nx, hops;
        nx = child_of(s, sym);
        if (nx != 0) return nx;
        hops = 0;
        while (s != 0 && hops < NUM_NODES) begin
            s  = fail_to[s];
            nx = child_of(s, sym);
            if (nx != 0) return nx;
            hops++;
        end
        return 0;
    endfunction

    function automatic t_rsp predict_result(t_req r);
        t_rsp res;
        int   nx;
        res = '{status: ST_OK, node: '0, match: 1'b0};
        case (r.mode)
            MODE_CLEAR: wipe_trie();
            MODE_ADD: begin
                nx = child_of(add_cursor, r.data_byte);
                links_ready = 0;
                if (nx == 0 && nodes_used >= NUM_NODES) begin
                    res.status = ST_FULL;
                    res.node   = add_cursor;
                    res.match  = word_end[add_cursor];
                    if (r.last_byte) add_cursor = 0;
                end else begin
                    if (nx == 0) begin
                        nx = nodes_used++;
                        goto_edge[add_cursor * ALPHABET + r.data_byte] = 8'(nx);
                    end
                    if (r.last_byte) begin
                        word_end[nx] = 1;
                        add_cursor   = 0;
                    end else begin
                        add_cursor = 8'(nx);
                    end
                    res.node  = 8'(nx);
                    res.match = word_end[nx];
                end
            end
            MODE_BUILD: begin
                link_trie();
                links_ready = 1;
                scan_at     = 0;
            end
            default: begin
                if (!links_ready) begin
                    res.status = ST_NOT_BUILT;
                end else begin
                    if (r.start_of_text) scan_at = 0;
                    scan_at   = 8'(walk_text(scan_at, r.data_byte));
                    res.node  = scan_at;
                    res.match = word_end[scan_at];
                end
            end
        endcase
        return res;
    endfunction

    initial begin
        wipe_trie();
        o_errors  = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && rsp.valid && rsp.ready) begin
            if (expected_results.size() == 0) begin
                $error("result with nothing expected: status %0d node %0d match %0d",
                       rsp.data.status, rsp.data.node, rsp.data.match);
                o_errors++;
            end else begin
                want = expected_results.pop_front();
                if (rsp.data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, rsp.data.status);
                    o_errors++;
                end
                if (rsp.data.node !== want.node) begin
                    $error("node: expected %0d, got %0d", want.node, rsp.data.node);
                    o_errors++;
                end
                if (rsp.data.match !== want.match) begin
                    $error("match: expected %0d, got %0d", want.match, rsp.data.match);
                    o_errors++;
                end
            end
        end
        if (i_rst_n && req.valid && req.ready)
            expected_results.push_back(predict_result(req.data));
        o_pending = expected_results.size();
    end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// Top of the matcher testbench: clock, reset, request stimulus and verdict.
module testbench;
    import ac_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   errors;
    int   pending;
    int   sent;
    bit   steady;     // when set, neither side idles

    ac_req_if req_ch ();
    ac_rsp_if rsp_ch ();

    aho_corasick_matcher u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    ac_trie_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Result side stalls about a quarter of the time unless in a steady stretch.
    always @(negedge i_clk)
        rsp_ch.ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 26);

    // Drive one request at the falling edge and hold it until the handshake.
    // Valid stays up after the handshake until the next request or an idle
    // cycle replaces it, so no posedge sees a stale request.
    task automatic send_request(t_mode m, logic [7:0] b, logic lb, logic sot);
        while (!steady && $urandom_range(0, 99) < 26) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= '{mode: m, data_byte: b, last_byte: lb, start_of_text: sot};
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        sent++;
    endtask

    // Adds one pattern; bytes come from a small alphabet (random when wide) so scans hit often.
    task automatic add_word(logic [7:0] alpha[4], int len, bit wide);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            b = wide ? 8'($urandom) : alpha[$urandom_range(0, 3)];
            send_request(MODE_ADD, b, i == len - 1, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic scan_text(logic [7:0] alpha[4], int len);
        for (int i = 0; i < len; i++)
            send_request(MODE_SCAN,
                         ($urandom_range(0, 19) == 0) ? 8'($urandom) : alpha[$urandom_range(0, 3)],
                         1'($urandom_range(0, 1)), $urandom_range(0, 9) == 0);
    endtask

    initial begin
        logic [7:0] alpha[4];
        int round;
        sent         = 0;
        steady       = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        rsp_ch.ready = 1'b0;
        i_rst_n      = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: scan before build, classic word set, extreme bytes,
        // scan after a late add (links stale), build of an empty trie.
        send_request(MODE_SCAN, 8'h68, 1'b0, 1'b1);
        send_request(MODE_BUILD, 8'h00, 1'b0, 1'b0);
        send_request(MODE_SCAN, 8'hFF, 1'b1, 1'b0);
        alpha = '{8'h68, 8'h65, 8'h73, 8'h72};
        send_request(MODE_ADD, 8'h68, 1'b0, 1'b0);
        send_request(MODE_ADD, 8'h65, 1'b1, 1'b0);       // "he"
        send_request(MODE_ADD, 8'h73, 1'b0, 1'b1);
        send_request(MODE_ADD, 8'h68, 1'b0, 1'b0);
        send_request(MODE_ADD, 8'h65, 1'b1, 1'b0);       // "she", suffix "he"
        send_request(MODE_ADD, 8'h00, 1'b0, 1'b0);
        send_request(MODE_ADD, 8'hFF, 1'b1, 1'b0);       // extreme bytes
        send_request(MODE_ADD, 8'h68, 1'b1, 1'b0);       // existing node gets a mark
        send_request(MODE_BUILD, 8'hFF, 1'b1, 1'b1);
        send_request(MODE_SCAN, 8'h73, 1'b0, 1'b1);
        send_request(MODE_SCAN, 8'h68, 1'b0, 1'b0);
        send_request(MODE_SCAN, 8'h65, 1'b0, 1'b0);
        send_request(MODE_SCAN, 8'h00, 1'b0, 1'b0);
        send_request(MODE_SCAN, 8'hFF, 1'b0, 1'b0);
        send_request(MODE_SCAN, 8'h65, 1'b0, 1'b1);
        send_request(MODE_ADD, 8'h72, 1'b1, 1'b0);
        send_request(MODE_SCAN, 8'h72, 1'b0, 1'b0);       // stale links
        send_request(MODE_CLEAR, 8'hFF, 1'b1, 1'b1);
        send_request(MODE_BUILD, 8'h00, 1'b0, 1'b0);
        send_request(MODE_SCAN, 8'h68, 1'b0, 1'b0);

        // Node table exhaustion: one long pattern, then further bytes drop.
        send_request(MODE_CLEAR, 8'h00, 1'b0, 1'b0);
        steady = 1'b1;
        for (int i = 0; i < 262; i++)
            send_request(MODE_ADD, 8'($urandom), i == 261, 1'b0);
        send_request(MODE_ADD, 8'h00, 1'b0, 1'b0);
        send_request(MODE_ADD, 8'hAA, 1'b1, 1'b0);
        steady = 1'b0;
        send_request(MODE_BUILD, 8'h00, 1'b0, 1'b0);
        scan_text(alpha, 10);

        // Random rounds of well-formed dictionaries and texts, plus noise.
        round = 0;
        while (sent < 1600) begin
            steady = (round % 9 == 4);
            foreach (alpha[i]) alpha[i] = 8'($urandom);
            if ($urandom_range(0, 3) != 0)
                send_request(MODE_CLEAR, 8'($urandom), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)));
            repeat ($urandom_range(1, 5))
                add_word(alpha, $urandom_range(1, 5), $urandom_range(0, 9) == 0);
            send_request(MODE_BUILD, 8'($urandom), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
            scan_text(alpha, $urandom_range(30, 80));
            if ($urandom_range(0, 4) == 0) begin
                // broken sequence: add without rebuilding, then scan
                add_word(alpha, $urandom_range(1, 3), 1'b0);
                scan_text(alpha, 3);
            end
            repeat ($urandom_range(0, 3))
                send_request(t_mode'($urandom_range(0, 3) == 2 ? MODE_SCAN
                             : t_mode'($urandom_range(0, 3) == 2 ? 3 : $urandom_range(0, 3))),
                             8'($urandom), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)));
            round++;
        end
        req_ch.valid <= 1'b0;
        steady = 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
        if (errors == 0)
            $display("aho_corasick_matcher verification clean");
        else
            $display("aho_corasick_matcher verification failed");
        $finish;
    end

    // Watchdog well above the slowest run (big builds take the longest).
    initial begin
        #200ms;
        $display("aho_corasick_matcher verification failed");
        $finish;
    end

endmodule

[sim.f]
rtl/ac_pkg.sv
rtl/ac_if.sv
rtl/ac_ram.sv
rtl/aho_corasick_matcher.sv
dv/ac_trie_checker.sv
dv/testbench.sv
